// ===== rtl/two_key_priority_queue_with_group_counts_defines.svh =====
// Assertion macros shared by the priority queue RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef TWO_KEY_PRIORITY_QUEUE_WITH_GROUP_COUNTS_DEFINES_SVH
`define TWO_KEY_PRIORITY_QUEUE_WITH_GROUP_COUNTS_DEFINES_SVH

// Invariant that holds at every clock edge out of reset.
`define TKPQ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TKPQ_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define TKPQ_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tkpq_pkg.sv =====
// Shared types and constants of the two-key priority queue.
// No dependencies.
`default_nettype none

package tkpq_pkg;

    localparam int CMD_W  = 2;
    localparam int TAG_W  = 16;
    localparam int AMT_W  = 16;
    localparam int GRP_W  = 5;
    localparam int STAT_W = 2;
    localparam int RCNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Kind of result the datapath registers onto the outputs
    typedef enum logic [2:0] {
        EM_NONE   = 3'd0,
        EM_OK     = 3'd1,
        EM_EMPTY  = 3'd2,
        EM_FULL   = 3'd3,
        EM_PEEK   = 3'd4,
        EM_REPORT = 3'd5
    } t_emit;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] amt;
        logic [GRP_W-1:0] grp;
    } t_entry;

    // Controller -> datapath commands
    typedef struct packed {
        logic  latch;          // capture input beat
        logic  walk_init;      // walk pointer to tail, walk count to occupancy
        logic  walk_step;      // step walk pointer back one slot
        logic  ent_rd_walk;    // entry read at slot before walk pointer (else head)
        logic  ent_wr_new;     // write captured entry at walk pointer
        logic  ent_wr_old;     // write read-back entry at walk pointer
        logic  cnt_from_entry; // counter read by group of read-back entry
        logic  cnt_from_rep;   // counter read by report index
        logic  push_commit;
        logic  pop_commit;
        logic  rep_init;
        logic  rep_step;
        t_emit emit;
    } t_ctrl;

    // Datapath -> controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic k_zero;     // walk reached the head
        logic old_first;  // read-back entry stays ahead of the new one
        logic rep_last;   // report index at the last group
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/tkpq_datapath.sv =====
// Datapath of the priority queue: circular sorted entry memory, pointers,
// group counter memory with valid bits, and the result register.
// Depends on tkpq_pkg and the assertion macro header.
`default_nettype none
`include "two_key_priority_queue_with_group_counts_defines.svh"

module tkpq_datapath #(
    parameter int CAPACITY   = 16,
    parameter int NUM_GROUPS = 23
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire tkpq_pkg::t_ctrl             i_ctrl,
    output tkpq_pkg::t_stat                  o_stat,
    input  wire logic [tkpq_pkg::TAG_W-1:0]  i_entry_tag,
    input  wire logic [tkpq_pkg::AMT_W-1:0]  i_amount,
    input  wire logic [tkpq_pkg::GRP_W-1:0]  i_group_id,
    output logic                             o_strobe,
    output logic [tkpq_pkg::STAT_W-1:0]      o_status,
    output logic [tkpq_pkg::TAG_W-1:0]       o_head_tag,
    output logic [tkpq_pkg::AMT_W-1:0]       o_head_amount,
    output logic [tkpq_pkg::GRP_W-1:0]       o_head_group,
    output logic [tkpq_pkg::GRP_W-1:0]       o_report_group,
    output logic [tkpq_pkg::RCNT_W-1:0]      o_report_count,
    output logic                             o_last
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int OW  = $clog2(CAPACITY + 1);
    localparam int GD  = NUM_GROUPS + 1;
    localparam int GIW = $clog2(GD);

    function automatic logic grp_in_range(input logic [tkpq_pkg::GRP_W-1:0] g);
        return (g != '0) && (int'(g) <= NUM_GROUPS);
    endfunction

    function automatic logic [GIW-1:0] cnt_idx(input logic [tkpq_pkg::GRP_W-1:0] g);
        return grp_in_range(g) ? GIW'(g) : '0;
    endfunction

    function automatic logic goes_before(input tkpq_pkg::t_entry a,
                                         input logic [tkpq_pkg::AMT_W-1:0] amt,
                                         input logic [tkpq_pkg::GRP_W-1:0] grp);
        if (a.amt != amt) begin
            return a.amt > amt;
        end
        return a.grp >= grp;
    endfunction

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // captured beat
    logic [tkpq_pkg::TAG_W-1:0] r_tag;
    logic [tkpq_pkg::AMT_W-1:0] r_amt;
    logic [tkpq_pkg::GRP_W-1:0] r_grp;

    // queue pointers
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_tail;
    logic [OW-1:0] r_occ;
    logic [AW-1:0] r_wp;
    logic [OW-1:0] r_k;
    logic [GIW-1:0] r_g;

    // entry memory
    tkpq_pkg::t_entry r_ent_mem [CAPACITY];
    tkpq_pkg::t_entry r_rd_q;

    // group counter memory
    logic [OW-1:0] r_cnt_mem [GD];
    logic [GD-1:0] r_cnt_vld;
    logic [OW-1:0] r_cnt_q;
    logic          r_cnt_q_vld;

    logic [AW-1:0]    w_wp_prev;
    logic [AW-1:0]    w_ent_raddr;
    logic             w_ent_we;
    tkpq_pkg::t_entry w_new;
    tkpq_pkg::t_entry w_ent_wdata;
    logic [GIW-1:0]   w_cnt_raddr;
    logic [OW-1:0]    w_cnt;
    logic             w_cnt_we;
    logic [OW-1:0]    w_cnt_wdata;
    logic [GIW-1:0]   w_cnt_waddr;

    assign w_wp_prev   = (r_wp == '0) ? AW'(CAPACITY - 1) : r_wp - 1'b1;
    assign w_ent_raddr = i_ctrl.ent_rd_walk ? w_wp_prev : r_base;
    assign w_new       = '{tag: r_tag, amt: r_amt, grp: r_grp};
    assign w_ent_wdata = i_ctrl.ent_wr_new ? w_new : r_rd_q;
    assign w_ent_we    = i_ctrl.ent_wr_new | i_ctrl.ent_wr_old;

    assign w_cnt_raddr = i_ctrl.cnt_from_rep   ? r_g :
                         i_ctrl.cnt_from_entry ? cnt_idx(r_rd_q.grp) : cnt_idx(r_grp);
    assign w_cnt       = r_cnt_q_vld ? r_cnt_q : '0;
    assign w_cnt_waddr = cnt_idx(r_grp);

    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_wdata = w_cnt;
        if (i_ctrl.push_commit && grp_in_range(r_grp)) begin
            w_cnt_we    = 1'b1;
            w_cnt_wdata = w_cnt + 1'b1;
        end else if (i_ctrl.pop_commit && grp_in_range(r_grp) && (w_cnt != '0)) begin
            w_cnt_we    = 1'b1;
            w_cnt_wdata = w_cnt - 1'b1;
        end
    end

    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.full      = (r_occ == OW'(CAPACITY));
    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.old_first = goes_before(r_rd_q, r_amt, r_grp);
    assign o_stat.rep_last  = (r_g == GIW'(NUM_GROUPS));

    // memories
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_ent_mem[r_wp] <= w_ent_wdata;
        end
        r_rd_q <= r_ent_mem[w_ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[w_cnt_raddr];
    end

    // captured payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_tag <= i_entry_tag;
            r_amt <= i_amount;
            r_grp <= i_group_id;
        end else if (i_ctrl.cnt_from_entry) begin
            r_grp <= r_rd_q.grp;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_g         <= '0;
            r_cnt_vld   <= '0;
            r_cnt_q_vld <= 1'b0;
        end else begin
            r_cnt_q_vld <= r_cnt_vld[w_cnt_raddr];
            if (w_cnt_we) begin
                r_cnt_vld[w_cnt_waddr] <= 1'b1;
            end
            if (i_ctrl.walk_init) begin
                r_wp <= r_tail;
                r_k  <= r_occ;
            end else if (i_ctrl.walk_step) begin
                r_wp <= w_wp_prev;
                r_k  <= r_k - 1'b1;
            end
            if (i_ctrl.push_commit) begin
                r_occ  <= r_occ + 1'b1;
                r_tail <= ptr_next(r_tail);
            end else if (i_ctrl.pop_commit) begin
                r_occ  <= r_occ - 1'b1;
                r_base <= ptr_next(r_base);
            end
            if (i_ctrl.rep_init) begin
                r_g <= GIW'(1);
            end else if (i_ctrl.rep_step) begin
                r_g <= r_g + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (i_ctrl.emit != tkpq_pkg::EM_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit != tkpq_pkg::EM_NONE) begin
            o_status       <= tkpq_pkg::ST_OK;
            o_head_tag     <= '0;
            o_head_amount  <= '0;
            o_head_group   <= '0;
            o_report_group <= '0;
            o_report_count <= '0;
            o_last         <= 1'b1;
            case (i_ctrl.emit)
                tkpq_pkg::EM_EMPTY: begin
                    o_status <= tkpq_pkg::ST_EMPTY;
                end
                tkpq_pkg::EM_FULL: begin
                    o_status <= tkpq_pkg::ST_FULL;
                end
                tkpq_pkg::EM_PEEK: begin
                    o_head_tag    <= r_rd_q.tag;
                    o_head_amount <= r_rd_q.amt;
                    o_head_group  <= r_rd_q.grp;
                end
                tkpq_pkg::EM_REPORT: begin
                    o_report_group <= tkpq_pkg::GRP_W'(r_g);
                    o_report_count <= tkpq_pkg::RCNT_W'(w_cnt);
                    o_last         <= o_stat.rep_last;
                end
                default: begin
                end
            endcase
        end
    end

    `TKPQ_ASSERT(a_occ_bound, r_occ <= OW'(CAPACITY), "occupancy above capacity")
    `TKPQ_IMPLY(a_push_room, i_ctrl.push_commit, r_occ != OW'(CAPACITY), "push commit when full")
    `TKPQ_IMPLY(a_pop_nonempty, i_ctrl.pop_commit, r_occ != '0, "pop commit when empty")

endmodule

`default_nettype wire

// ===== rtl/tkpq_ctrl.sv =====
// Controller of the priority queue: one-hot sequencer over push walk,
// pop, peek and group report.
// Depends on tkpq_pkg.
`default_nettype none

module tkpq_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tkpq_pkg::CMD_W-1:0]  i_command,
    input  wire tkpq_pkg::t_stat             i_stat,
    output tkpq_pkg::t_ctrl                  o_ctrl
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_P_CHK   = 9'b000000010,
        S_P_CMP   = 9'b000000100,
        S_P_FIN   = 9'b000001000,
        S_POP_CNT = 9'b000010000,
        S_POP_FIN = 9'b000100000,
        S_PEEK_EM = 9'b001000000,
        S_REP_RD  = 9'b010000000,
        S_REP_EM  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_ctrl      = '0;
        o_ctrl.emit = tkpq_pkg::EM_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.latch = 1'b1;
                    case (tkpq_pkg::t_cmd'(i_command))
                        tkpq_pkg::CMD_PUSH: begin
                            if (i_stat.full) begin
                                o_ctrl.emit = tkpq_pkg::EM_FULL;
                            end else begin
                                o_ctrl.walk_init = 1'b1;
                                n_state          = S_P_CHK;
                            end
                        end
                        tkpq_pkg::CMD_POP: begin
                            if (i_stat.empty) begin
                                o_ctrl.emit = tkpq_pkg::EM_EMPTY;
                            end else begin
                                n_state = S_POP_CNT;
                            end
                        end
                        tkpq_pkg::CMD_PEEK: begin
                            if (i_stat.empty) begin
                                o_ctrl.emit = tkpq_pkg::EM_EMPTY;
                            end else begin
                                n_state = S_PEEK_EM;
                            end
                        end
                        tkpq_pkg::CMD_REPORT: begin
                            o_ctrl.rep_init = 1'b1;
                            n_state         = S_REP_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_P_CHK: begin
                if (i_stat.k_zero) begin
                    o_ctrl.ent_wr_new = 1'b1;
                    n_state           = S_P_FIN;
                end else begin
                    o_ctrl.ent_rd_walk = 1'b1;
                    n_state            = S_P_CMP;
                end
            end
            S_P_CMP: begin
                if (i_stat.old_first) begin
                    o_ctrl.ent_wr_new = 1'b1;
                    n_state           = S_P_FIN;
                end else begin
                    o_ctrl.ent_wr_old = 1'b1;
                    o_ctrl.walk_step  = 1'b1;
                    n_state           = S_P_CHK;
                end
            end
            S_P_FIN: begin
                o_ctrl.push_commit = 1'b1;
                o_ctrl.emit        = tkpq_pkg::EM_OK;
                n_state            = S_IDLE;
            end
            S_POP_CNT: begin
                o_ctrl.cnt_from_entry = 1'b1;
                n_state               = S_POP_FIN;
            end
            S_POP_FIN: begin
                o_ctrl.pop_commit = 1'b1;
                o_ctrl.emit       = tkpq_pkg::EM_OK;
                n_state           = S_IDLE;
            end
            S_PEEK_EM: begin
                o_ctrl.emit = tkpq_pkg::EM_PEEK;
                n_state     = S_IDLE;
            end
            S_REP_RD: begin
                o_ctrl.cnt_from_rep = 1'b1;
                n_state             = S_REP_EM;
            end
            S_REP_EM: begin
                o_ctrl.emit = tkpq_pkg::EM_REPORT;
                if (i_stat.rep_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctrl.rep_step = 1'b1;
                    n_state         = S_REP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_key_priority_queue_with_group_counts.sv =====
// Top level of the two-key priority queue with per-group entry counts.
// Depends on tkpq_pkg, tkpq_ctrl, tkpq_datapath and the assertion macro header.
//
// A command beat is taken when start is high and busy is low. Every result
// beat shows on the o_ ports for one cycle with o_strobe high; there is no
// way to stall results, so the receiver must take each one as it comes.
// Entries are kept sorted, larger amount first, then larger group, then
// arrival order. Push into a full queue, and pop or peek on an empty one,
// answer in the next cycle. Peek reads the head, then registers it; pop
// reads the head, then does a read-modify-write of its group counter. A
// push walks back from the tail, one read and one write per queued entry
// that ranks behind the new one, then writes the new entry in its slot. A
// count report gives NUM_GROUPS beats, groups 1 upward, each a counter
// memory read followed by a result beat, with o_last on the final beat
// only. busy is low on the strobe cycle of a single-beat command, so the
// next command can be taken then. No clearing pass is needed after reset:
// counters carry valid bits and only written entry slots are read.
// Group numbers of 0 or above NUM_GROUPS queue and sort normally but are
// not counted.
`default_nettype none
`include "two_key_priority_queue_with_group_counts_defines.svh"

module two_key_priority_queue_with_group_counts #(
    parameter int CAPACITY   = 16,
    parameter int NUM_GROUPS = 23
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tkpq_pkg::CMD_W-1:0]  i_command,
    input  wire logic [tkpq_pkg::TAG_W-1:0]  i_entry_tag,
    input  wire logic [tkpq_pkg::AMT_W-1:0]  i_amount,
    input  wire logic [tkpq_pkg::GRP_W-1:0]  i_group_id,
    output logic                             o_strobe,
    output logic [tkpq_pkg::STAT_W-1:0]      o_status,
    output logic [tkpq_pkg::TAG_W-1:0]       o_head_tag,
    output logic [tkpq_pkg::AMT_W-1:0]       o_head_amount,
    output logic [tkpq_pkg::GRP_W-1:0]       o_head_group,
    output logic [tkpq_pkg::GRP_W-1:0]       o_report_group,
    output logic [tkpq_pkg::RCNT_W-1:0]      o_report_count,
    output logic                             o_last
);

    tkpq_pkg::t_ctrl w_ctrl;
    tkpq_pkg::t_stat w_stat;

    // sequencer: decodes the command beat and steps the datapath
    tkpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_ctrl    (w_ctrl)
    );

    // storage, pointers, counters and the result register
    tkpq_datapath #(
        .CAPACITY   (CAPACITY),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_entry_tag    (i_entry_tag),
        .i_amount       (i_amount),
        .i_group_id     (i_group_id),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_head_tag     (o_head_tag),
        .o_head_amount  (o_head_amount),
        .o_head_group   (o_head_group),
        .o_report_group (o_report_group),
        .o_report_count (o_report_count),
        .o_last         (o_last)
    );

    // a report beat that is not the last keeps the block busy
    `TKPQ_IMPLY(a_report_busy, o_strobe && !o_last, busy, "non-final beat while idle")
    // an accepted command either answers next cycle or holds busy
    `TKPQ_NEXT(a_accept_progress, start && !busy, o_strobe || busy, "command beat lost")

endmodule

`default_nettype wire

// ===== bench/two_key_priority_queue_with_group_counts_tb.sv =====
// Self-checking bench for the two-key sorted priority queue with group counts.
// Needs tkpq_pkg and the two_key_priority_queue_with_group_counts RTL; runs a
// directed table, then random command beats, and checks every result beat.
`default_nettype none

module two_key_priority_queue_with_group_counts_tb;
    import tkpq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int NUM_GROUPS  = 23;
    localparam int RANDOM_CMDS = 320;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 64;     // longer than the slowest push walk

    // One result beat as the ports show it
    typedef struct packed {
        t_status             status;
        logic [TAG_W-1:0]    head_tag;
        logic [AMT_W-1:0]    head_amount;
        logic [GRP_W-1:0]    head_group;
        logic [GRP_W-1:0]    report_group;
        logic [RCNT_W-1:0]   report_count;
        logic                last;
    } reply_t;

    // Directed table row. pin marks rows whose single reply is typed in;
    // reps repeats the row, bumping the tag each time.
    typedef struct packed {
        t_cmd                cmd;
        logic [TAG_W-1:0]    tag;
        logic [AMT_W-1:0]    amt;
        logic [GRP_W-1:0]    grp;
        logic [4:0]          reps;
        logic                pin;
        t_status             st;
        logic [TAG_W-1:0]    htag;
        logic [AMT_W-1:0]    hamt;
        logic [GRP_W-1:0]    hgrp;
    } stim_row_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic [CMD_W-1:0]    i_command     = '0;
    logic [TAG_W-1:0]    i_entry_tag   = '0;
    logic [AMT_W-1:0]    i_amount      = '0;
    logic [GRP_W-1:0]    i_group_id    = '0;
    logic                busy;
    logic                o_strobe;
    logic [STAT_W-1:0]   o_status;
    logic [TAG_W-1:0]    o_head_tag;
    logic [AMT_W-1:0]    o_head_amount;
    logic [GRP_W-1:0]    o_head_group;
    logic [GRP_W-1:0]    o_report_group;
    logic [RCNT_W-1:0]   o_report_count;
    logic                o_last;

    // Typed expectation travels with the command beat it belongs to
    logic                drv_pinned       = 1'b0;
    reply_t              drv_pinned_reply = '0;

    two_key_priority_queue_with_group_counts #(
        .CAPACITY   (CAPACITY),
        .NUM_GROUPS (NUM_GROUPS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_entry_tag    (i_entry_tag),
        .i_amount       (i_amount),
        .i_group_id     (i_group_id),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_head_tag     (o_head_tag),
        .o_head_amount  (o_head_amount),
        .o_head_group   (o_head_group),
        .o_report_group (o_report_group),
        .o_report_count (o_report_count),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Queue model: sorted entry list, occupancy and per-group counters
    // ------------------------------------------------------------------
    logic [TAG_W-1:0] model_tag [CAPACITY];
    logic [AMT_W-1:0] model_amt [CAPACITY];
    logic [GRP_W-1:0] model_grp [CAPACITY];
    int               model_occ;
    int               model_grp_cnt [1:NUM_GROUPS];

    reply_t expected_replies [$];   // beats still owed by the block, oldest first
    reply_t fresh_replies [$];      // beats caused by the command just taken

    int errors;
    int cycles;
    int beats_checked;
    int n_push, n_pop, n_peek, n_report, n_full_drops, n_empty_hits;

    function automatic reply_t make_reply(t_status st, logic [TAG_W-1:0] tag,
                                          logic [AMT_W-1:0] amt, logic [GRP_W-1:0] grp,
                                          logic [GRP_W-1:0] rg, logic [RCNT_W-1:0] rc,
                                          logic lst);
        reply_t r;
        r.status       = st;
        r.head_tag     = tag;
        r.head_amount  = amt;
        r.head_group   = grp;
        r.report_group = rg;
        r.report_count = rc;
        r.last         = lst;
        return r;
    endfunction

    function automatic bit group_counted(logic [GRP_W-1:0] g);
        return g >= 1 && g <= NUM_GROUPS;
    endfunction

    // Apply one command to the model and queue up the beats it should cause
    function automatic void apply_to_queue_model(t_cmd cmd, logic [TAG_W-1:0] tag,
                                                 logic [AMT_W-1:0] amt,
                                                 logic [GRP_W-1:0] grp);
        int pos;
        case (cmd)
            CMD_PUSH: begin
                n_push++;
                if (model_occ >= CAPACITY) begin
                    n_full_drops++;
                    fresh_replies.push_back(make_reply(ST_FULL, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    // queued entries with a higher key, or an equal one, stay ahead
                    pos = 0;
                    while (pos < model_occ &&
                           (model_amt[pos] > amt ||
                            (model_amt[pos] == amt && model_grp[pos] >= grp)))
                        pos++;
                    for (int i = model_occ; i > pos; i--) begin
                        model_tag[i] = model_tag[i-1];
                        model_amt[i] = model_amt[i-1];
                        model_grp[i] = model_grp[i-1];
                    end
                    model_tag[pos] = tag;
                    model_amt[pos] = amt;
                    model_grp[pos] = grp;
                    model_occ++;
                    if (group_counted(grp))
                        model_grp_cnt[grp]++;
                    fresh_replies.push_back(make_reply(ST_OK, 0, 0, 0, 0, 0, 1'b1));
                end
            end
            CMD_POP: begin
                n_pop++;
                if (model_occ == 0) begin
                    n_empty_hits++;
                    fresh_replies.push_back(make_reply(ST_EMPTY, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    if (group_counted(model_grp[0]) && model_grp_cnt[model_grp[0]] > 0)
                        model_grp_cnt[model_grp[0]]--;
                    for (int i = 1; i < model_occ; i++) begin
                        model_tag[i-1] = model_tag[i];
                        model_amt[i-1] = model_amt[i];
                        model_grp[i-1] = model_grp[i];
                    end
                    model_occ--;
                    fresh_replies.push_back(make_reply(ST_OK, 0, 0, 0, 0, 0, 1'b1));
                end
            end
            CMD_PEEK: begin
                n_peek++;
                if (model_occ == 0) begin
                    n_empty_hits++;
                    fresh_replies.push_back(make_reply(ST_EMPTY, 0, 0, 0, 0, 0, 1'b1));
                end else begin
                    fresh_replies.push_back(make_reply(ST_OK, model_tag[0], model_amt[0],
                                                       model_grp[0], 0, 0, 1'b1));
                end
            end
            default: begin
                // count report: one beat per group, last flag on the final group
                n_report++;
                for (int g = 1; g <= NUM_GROUPS; g++)
                    fresh_replies.push_back(make_reply(ST_OK, 0, 0, 0, GRP_W'(g),
                                                       RCNT_W'(model_grp_cnt[g]),
                                                       g == NUM_GROUPS));
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check the result beat first (it belongs to an older command),
    // then predict for a command beat taken at the same edge.
    // ------------------------------------------------------------------
    initial begin
        model_occ = 0;
        foreach (model_grp_cnt[g]) model_grp_cnt[g] = 0;
    end

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n && o_strobe === 1'b1) begin
            beats_checked++;
            if (expected_replies.size() == 0) begin
                $error("result beat with nothing expected: status %0h", o_status);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                check_field("status",       want.status,       o_status);
                check_field("head_tag",     want.head_tag,     o_head_tag);
                check_field("head_amount",  want.head_amount,  o_head_amount);
                check_field("head_group",   want.head_group,   o_head_group);
                check_field("report_group", want.report_group, o_report_group);
                check_field("report_count", want.report_count, o_report_count);
                check_field("last",         want.last,         o_last);
            end
        end
        if (i_rst_n && start && !busy) begin
            fresh_replies.delete();
            apply_to_queue_model(t_cmd'(i_command), i_entry_tag, i_amount, i_group_id);
            if (drv_pinned)
                expected_replies.push_back(drv_pinned_reply);
            else
                foreach (fresh_replies[k]) expected_replies.push_back(fresh_replies[k]);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycles, expected_replies.size());
            $display("** two_key_priority_queue_with_group_counts: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // Put a command beat up and hold it until the block takes it.
    // Returns at the accepting edge, so the caller may drive the next beat there.
    task automatic send_command(input t_cmd cmd, input logic [TAG_W-1:0] tag,
                                input logic [AMT_W-1:0] amt, input logic [GRP_W-1:0] grp,
                                input logic pin, input reply_t pin_reply);
        start            <= 1'b1;
        i_command        <= cmd;
        i_entry_tag      <= tag;
        i_amount         <= amt;
        i_group_id       <= grp;
        drv_pinned       <= pin;
        drv_pinned_reply <= pin_reply;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Sender gap: about 30 in 100 beats are followed by a random run of idle cycles
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Hold off until every owed beat has come back
    task automatic wait_for_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_cmd pick_command(int phase);
        int r;
        int p_push, p_pop, p_peek;
        r = $urandom_range(0, 99);
        case (phase)
            0:       begin p_push = 70; p_pop = 15; p_peek = 10; end  // fill, hit full
            2:       begin p_push = 20; p_pop = 60; p_peek = 15; end  // drain, hit empty
            default: begin p_push = 42; p_pop = 35; p_peek = 13; end
        endcase
        if (r < p_push)                 return CMD_PUSH;
        if (r < p_push + p_pop)         return CMD_POP;
        if (r < p_push + p_pop + p_peek) return CMD_PEEK;
        return CMD_REPORT;
    endfunction

    // Small amount ranges make key ties common, so arrival order gets exercised
    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0, 1, 2: return AMT_W'($urandom_range(0, 3));
            3:       return $urandom_range(0, 1) ? '1 : '0;
            default: return AMT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly counted groups; some ties, some uncounted (0 and above NUM_GROUPS)
    function automatic logic [GRP_W-1:0] pick_group();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return GRP_W'($urandom_range(1, NUM_GROUPS));
            6:                return GRP_W'($urandom_range(1, 3));
            7:                return $urandom_range(0, 1) ? GRP_W'(NUM_GROUPS) : GRP_W'(1);
            8:                return '0;
            default:          return GRP_W'($urandom_range(NUM_GROUPS + 1, 31));
        endcase
    endfunction

    // Directed table: empty/full edges, key extremes, uncounted groups,
    // tie ordering, and a group counter driven up to the queue capacity.
    stim_row_t directed_rows [0:24] = '{
        '{CMD_PEEK,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_EMPTY, 16'h0,    16'h0,    5'd0},
        '{CMD_POP,    16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_EMPTY, 16'h0,    16'h0,    5'd0},
        '{CMD_REPORT, 16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'hFFFF, 16'hFFFF, 5'd23, 5'd1,  1'b1, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h0000, 16'h0000, 5'd1,  5'd1,  1'b1, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PEEK,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_OK,    16'hFFFF, 16'hFFFF, 5'd23},
        '{CMD_PUSH,   16'h1234, 16'h1000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h5678, 16'h1000, 5'd31, 5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'hAAAA, 16'h1000, 5'd5,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h5555, 16'h1000, 5'd5,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_REPORT, 16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_POP,    16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PEEK,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h0100, 16'h8000, 5'd7,  5'd11, 1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'hBEEF, 16'hFFFF, 5'd23, 5'd1,  1'b1, ST_FULL,  16'h0,    16'h0,    5'd0},
        '{CMD_PEEK,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_REPORT, 16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_POP,    16'h0000, 16'h0000, 5'd0,  5'd16, 1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_POP,    16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_EMPTY, 16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h0200, 16'h00FF, 5'd23, 5'd16, 1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_REPORT, 16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PUSH,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_FULL,  16'h0,    16'h0,    5'd0},
        '{CMD_POP,    16'h0000, 16'h0000, 5'd0,  5'd16, 1'b0, ST_OK,    16'h0,    16'h0,    5'd0},
        '{CMD_PEEK,   16'h0000, 16'h0000, 5'd0,  5'd1,  1'b1, ST_EMPTY, 16'h0,    16'h0,    5'd0},
        '{CMD_REPORT, 16'h0000, 16'h0000, 5'd0,  5'd1,  1'b0, ST_OK,    16'h0,    16'h0,    5'd0}
    };

    initial begin
        stim_row_t row;
        t_cmd      cmd;
        int        phase;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++) begin
                send_command(row.cmd, row.tag + TAG_W'(k), row.amt, row.grp, row.pin,
                             make_reply(row.st, row.htag, row.hamt, row.hgrp, 0, 0, 1'b1));
                maybe_idle(1'b1);
            end
        end
        wait_for_replies();

        // Random part in four phases: fill-heavy, back-to-back balanced,
        // drain-heavy, balanced. Phase 1 runs with no sender gaps between its commands.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            phase = n / (RANDOM_CMDS / 4);
            if (n % (RANDOM_CMDS / 4) == 0 ||
                (phase != 1 && $urandom_range(0, 99) < 3))
                wait_for_replies();
            cmd = pick_command(phase);
            send_command(cmd, TAG_W'($urandom_range(0, 65535)), pick_amount(),
                         pick_group(), 1'b0, '0);
            maybe_idle(phase != 1);
        end

        // Let the last beats come back, then watch for strays
        wait_for_replies();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_replies.size());
            errors++;
        end

        $display("Ran %0d push, %0d pop, %0d peek and %0d count commands",
                 n_push, n_pop, n_peek, n_report);
        $display("(%0d full drops, %0d empty replies); compared %0d result beats, %0d mismatches.",
                 n_full_drops, n_empty_hits, beats_checked, errors);
        if (errors == 0)
            $display("** two_key_priority_queue_with_group_counts: PASSED **");
        else
            $display("** two_key_priority_queue_with_group_counts: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tkpq_pkg.sv
rtl/tkpq_datapath.sv
rtl/tkpq_ctrl.sv
rtl/two_key_priority_queue_with_group_counts.sv
bench/two_key_priority_queue_with_group_counts_tb.sv
